// ===== hdl/mst_pkg.sv =====
// Shared types and constants for the multitouch slot tracker.
// Used by mst_ctrl, mst_dpath and multitouch_slot_tracker_unit; depends on nothing.
package mst_pkg;

    // Configuration port geometry
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FLIP_H        = 3'd2;
    localparam logic [2:0] REG_FLIP_V        = 3'd3;
    localparam logic [2:0] REG_SWAP_AXES     = 3'd4;

    // Field widths
    localparam int unsigned COORD_W = 12;
    localparam int unsigned SIZE_W  = 13;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned VALUE_W = 17;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd800;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

    // Output event codes
    localparam logic [CODE_W-1:0] EVC_SLOT  = 3'd0;
    localparam logic [CODE_W-1:0] EVC_TRACK = 3'd1;
    localparam logic [CODE_W-1:0] EVC_TOOL  = 3'd2;
    localparam logic [CODE_W-1:0] EVC_POS_X = 3'd3;
    localparam logic [CODE_W-1:0] EVC_POS_Y = 3'd4;
    localparam logic [CODE_W-1:0] EVC_SYNC  = 3'd5;

    // Input item kinds and touch event types
    localparam logic       KIND_POINT = 1'b0;
    localparam logic       KIND_FRAME = 1'b1;
    localparam logic [1:0] TYPE_DOWN    = 2'd0;
    localparam logic [1:0] TYPE_CONTACT = 2'd2;

    // Which event the output register loads
    typedef enum logic [2:0] {
        EV_PT_SLOT,
        EV_PT_TRACK,
        EV_PT_TOOL,
        EV_PT_X,
        EV_PT_Y,
        EV_REL_SLOT,
        EV_REL_TRACK,
        EV_SYNC
    } t_ev_sel;

    typedef struct packed {
        logic    accept;
        logic    scan_clr;
        logic    scan_inc;
        logic    load_out;
        t_ev_sel ev_sel;
        logic    last;
    } t_cmd;

    typedef struct packed {
        logic pt_emit;
        logic rel_bit;
        logic scan_last;
        logic sync_need;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/mst_ctrl.sv =====
// Controller state machine for the multitouch slot tracker.
// Depends on mst_pkg; drives the datapath in mst_dpath through t_cmd.
module mst_ctrl
    import mst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_kind,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POINT,
        S_SCAN,
        S_REL_TRACK,
        S_SYNC
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_cmd.accept    = 1'b0;
        o_cmd.scan_clr  = 1'b0;
        o_cmd.scan_inc  = 1'b0;
        o_cmd.load_out  = 1'b0;
        o_cmd.ev_sel    = EV_SYNC;
        o_cmd.last      = 1'b0;
        o_in_stall      = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == KIND_FRAME) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end else if (i_sts.pt_emit) begin
                        n_step  = 3'd0;
                        n_state = S_POINT;
                    end
                end
            end
            S_POINT: begin
                case (r_step)
                    3'd0:    o_cmd.ev_sel = EV_PT_SLOT;
                    3'd1:    o_cmd.ev_sel = EV_PT_TRACK;
                    3'd2:    o_cmd.ev_sel = EV_PT_TOOL;
                    3'd3:    o_cmd.ev_sel = EV_PT_X;
                    default: o_cmd.ev_sel = EV_PT_Y;
                endcase
                o_cmd.last = (r_step == 3'd4);
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (r_step == 3'd4) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.ev_sel = EV_REL_SLOT;
                if (i_sts.rel_bit) begin
                    if (i_sts.out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_REL_TRACK;
                    end
                end else if (i_sts.scan_last) begin
                    n_state = S_SYNC;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_REL_TRACK: begin
                o_cmd.ev_sel = EV_REL_TRACK;
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = S_SYNC;
                    end else begin
                        o_cmd.scan_inc = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SYNC: begin
                o_cmd.ev_sel = EV_SYNC;
                o_cmd.last   = 1'b1;
                if (!i_sts.sync_need) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== hdl/mst_dpath.sv =====
// Datapath of the multitouch slot tracker: configuration registers, slot table,
// frame masks, scan counter and the output event register. Depends on mst_pkg.
module mst_dpath
    import mst_pkg::*;
#(
    parameter int SLOT_COUNT       = 10,
    parameter int TRACKING_ID_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    // input item fields
    input  logic                      i_kind,
    input  logic [7:0]                i_x_high,
    input  logic [7:0]                i_x_low,
    input  logic [7:0]                i_y_high,
    input  logic [7:0]                i_y_low,
    // output event
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [CODE_W-1:0]         o_event_code,
    output logic signed [VALUE_W-1:0] o_event_value,
    output logic                      o_last_event,
    // controller link
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Configuration registers
    logic [SIZE_W-1:0] r_width, r_height;
    logic              r_flip_h, r_flip_v, r_swap;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_flip_h <= 1'b1;
            r_flip_v <= 1'b1;
            r_swap   <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SCREEN_WIDTH:  r_width  <= pwdata[SIZE_W-1:0];
                REG_SCREEN_HEIGHT: r_height <= pwdata[SIZE_W-1:0];
                REG_FLIP_H:        r_flip_h <= pwdata[0];
                REG_FLIP_V:        r_flip_v <= pwdata[0];
                REG_SWAP_AXES:     r_swap   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SCREEN_WIDTH:  prdata = DATA_W'(r_width);
            REG_SCREEN_HEIGHT: prdata = DATA_W'(r_height);
            REG_FLIP_H:        prdata = DATA_W'(r_flip_h);
            REG_FLIP_V:        prdata = DATA_W'(r_flip_v);
            REG_SWAP_AXES:     prdata = DATA_W'(r_swap);
            default:           prdata = '0;
        endcase
    end

    // Decode of the incoming point record
    logic [COORD_W-1:0] in_x, in_y;
    logic [3:0]         in_id;
    logic [1:0]         in_type;
    logic               id_ok, is_point, type_emit;
    logic [SLOT_W-1:0]  id_idx;

    assign in_x      = {i_x_high[3:0], i_x_low};
    assign in_y      = {i_y_high[3:0], i_y_low};
    assign in_id     = i_y_high[7:4];
    assign in_type   = i_x_high[7:6];
    assign id_ok     = (32'(in_id) < 32'(SLOT_COUNT));
    assign is_point  = (i_kind == KIND_POINT);
    assign type_emit = (in_type == TYPE_DOWN) || (in_type == TYPE_CONTACT);
    assign id_idx    = in_id[SLOT_W-1:0];

    // Mirror as size - 1 - c, clamped at zero, then the optional swap.
    logic signed [SIZE_W+1:0] mir_x, mir_y;
    logic [SIZE_W-1:0]        fx, fy;

    assign mir_x = $signed({2'b00, r_width}) - 15'sd1 - $signed({3'b000, in_x});
    assign mir_y = $signed({2'b00, r_height}) - 15'sd1 - $signed({3'b000, in_y});

    always_comb begin
        if (r_flip_h) begin
            fx = mir_x[SIZE_W+1] ? '0 : mir_x[SIZE_W-1:0];
        end else begin
            fx = SIZE_W'(in_x);
        end
        if (r_flip_v) begin
            fy = mir_y[SIZE_W+1] ? '0 : mir_y[SIZE_W-1:0];
        end else begin
            fy = SIZE_W'(in_y);
        end
    end

    // Tracking state
    logic [TRACKING_ID_BITS-1:0] r_slot_id [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]       r_slot_vld;
    logic [TRACKING_ID_BITS-1:0] r_next_id;
    logic [SLOT_COUNT-1:0]       r_known, r_seen, r_rel;
    logic                        r_frame_emitted, r_sync_need;
    logic [SLOT_W-1:0]           r_scan;
    logic [SIZE_W-1:0]           r_x, r_y;
    logic [SLOT_W-1:0]           r_id;
    logic [SLOT_COUNT-1:0]       released;
    logic                        pt_emit;

    assign released = r_known & ~r_seen;
    assign pt_emit  = is_point && id_ok && type_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld      <= '0;
            r_next_id       <= '0;
            r_known         <= '0;
            r_seen          <= '0;
            r_rel           <= '0;
            r_frame_emitted <= 1'b0;
            r_sync_need     <= 1'b0;
            r_scan          <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (!is_point) begin
                    // End of frame: free released slots and roll the masks.
                    r_rel           <= released;
                    r_slot_vld      <= r_slot_vld & ~released;
                    r_sync_need     <= (released != '0) || r_frame_emitted;
                    r_known         <= r_seen;
                    r_seen          <= '0;
                    r_frame_emitted <= 1'b0;
                end else if (id_ok) begin
                    r_seen[id_idx] <= 1'b1;
                    if (type_emit) begin
                        r_frame_emitted <= 1'b1;
                        if (!r_slot_vld[id_idx]) begin
                            r_slot_vld[id_idx] <= 1'b1;
                            r_next_id          <= r_next_id + TRACKING_ID_BITS'(1);
                        end
                    end
                end
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + SLOT_W'(1);
            end
        end
    end

    // Payload captured with the point record
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && pt_emit) begin
            r_x  <= r_swap ? fy : fx;
            r_y  <= r_swap ? fx : fy;
            r_id <= id_idx;
            if (!r_slot_vld[id_idx]) begin
                r_slot_id[id_idx] <= r_next_id;
            end
        end
    end

    // Output event register
    logic                      r_out_vld, r_last;
    logic [CODE_W-1:0]         r_code;
    logic [VALUE_W-1:0]        r_val;
    logic                      out_free;
    logic [31:0]               trk_ext;
    logic [CODE_W-1:0]         sel_code;
    logic [VALUE_W-1:0]        sel_val;

    assign out_free = !r_out_vld || !i_out_stall;
    assign trk_ext  = 32'(r_slot_id[r_id]);

    always_comb begin
        case (i_cmd.ev_sel)
            EV_PT_SLOT: begin
                sel_code = EVC_SLOT;
                sel_val  = VALUE_W'(r_id);
            end
            EV_PT_TRACK: begin
                sel_code = EVC_TRACK;
                sel_val  = trk_ext[VALUE_W-1:0];
            end
            EV_PT_TOOL: begin
                sel_code = EVC_TOOL;
                sel_val  = '0;
            end
            EV_PT_X: begin
                sel_code = EVC_POS_X;
                sel_val  = VALUE_W'(r_x);
            end
            EV_PT_Y: begin
                sel_code = EVC_POS_Y;
                sel_val  = VALUE_W'(r_y);
            end
            EV_REL_SLOT: begin
                sel_code = EVC_SLOT;
                sel_val  = VALUE_W'(r_scan);
            end
            EV_REL_TRACK: begin
                sel_code = EVC_TRACK;
                sel_val  = '1;
            end
            default: begin
                sel_code = EVC_SYNC;
                sel_val  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_code <= sel_code;
            r_val  <= sel_val;
            r_last <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_event_code  = r_code;
    assign o_event_value = $signed(r_val);
    assign o_last_event  = r_last;

    assign o_sts.pt_emit   = pt_emit;
    assign o_sts.rel_bit   = r_rel[r_scan];
    assign o_sts.scan_last = (r_scan == SLOT_W'(SLOT_COUNT - 1));
    assign o_sts.sync_need = r_sync_need;
    assign o_sts.out_free  = out_free;

endmodule

// ===== hdl/multitouch_slot_tracker_unit.sv =====
// Multitouch slot tracker top level: joins the controller and the datapath.
// Depends on mst_pkg, mst_ctrl and mst_dpath.
//
// Takes one raw touch point record or end-of-frame mark per input transaction
// and produces protocol B style events on the output channel, one per cycle
// at most, through a single output register. A press or contact point is
// accepted and then gives five events in S_POINT; a lift-up point, a point with an
// id of SLOT_COUNT or more, or any point type without events is only accepted.
// An end-of-frame mark is accepted, then the controller walks the slots one per
// cycle unless a release waits on a stalled output, passes through S_REL_TRACK
// for the second event of each release and ends in S_SYNC. Configuration
// registers sit on the APB-style port at byte addresses 0, 4, 8, 12 and 16 and
// should be written while idle.
module multitouch_slot_tracker_unit
    import mst_pkg::*;
#(
    parameter int SLOT_COUNT       = 10,
    parameter int TRACKING_ID_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic [7:0]                i_x_high,
    input  logic [7:0]                i_x_low,
    input  logic [7:0]                i_y_high,
    input  logic [7:0]                i_y_low,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [CODE_W-1:0]         o_event_code,
    output logic signed [VALUE_W-1:0] o_event_value,
    output logic                      o_last_event
);

    t_cmd cmd;
    t_sts sts;

    mst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mst_dpath #(
        .SLOT_COUNT       (SLOT_COUNT),
        .TRACKING_ID_BITS (TRACKING_ID_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_kind        (i_kind),
        .i_x_high      (i_x_high),
        .i_x_low       (i_x_low),
        .i_y_high      (i_y_high),
        .i_y_low       (i_y_low),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_code  (o_event_code),
        .o_event_value (o_event_value),
        .o_last_event  (o_last_event),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

// ===== sim/mst_event_checker.sv =====
// Scoreboard for the multitouch slot tracker: snoops the APB port and both channels,
// predicts the protocol B event stream and compares it with the block's output.
// Depends on mst_pkg only.
module mst_event_checker
    import mst_pkg::*;
#(
    parameter int SLOT_COUNT       = 10,
    parameter int TRACKING_ID_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic                      i_pready,
    input  logic [ADDR_W-1:0]         i_paddr,
    input  logic [DATA_W-1:0]         i_pwdata,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_kind,
    input  logic [7:0]                i_x_high,
    input  logic [7:0]                i_x_low,
    input  logic [7:0]                i_y_high,
    input  logic [7:0]                i_y_low,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [CODE_W-1:0]         i_event_code,
    input  logic signed [VALUE_W-1:0] i_event_value,
    input  logic                      i_last_event,
    output int                        o_pending,
    output int                        o_failures
);

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_touch_event;

    localparam int MAX_EVENTS = 2 * SLOT_COUNT + 1;

    t_touch_event expected_events[$];
    t_touch_event staged[MAX_EVENTS];
    int           staged_n;
    int           mismatch_count;

    // Shadow copy of the configuration registers
    logic [SIZE_W-1:0] screen_w;
    logic [SIZE_W-1:0] screen_h;
    logic              mirror_x;
    logic              mirror_y;
    logic              swap_xy;

    // Shadow copy of the slot tracking state
    logic                        slot_busy[SLOT_COUNT];
    logic [TRACKING_ID_BITS-1:0] slot_track[SLOT_COUNT];
    logic [TRACKING_ID_BITS-1:0] next_track;
    logic [SLOT_COUNT-1:0]       known_mask;
    logic [SLOT_COUNT-1:0]       seen_mask;
    logic                        frame_active;

    function automatic logic [VALUE_W-1:0] mirror_coord(input logic [SIZE_W-1:0] size,
                                                        input logic [COORD_W-1:0] c);
        int v;
        v = int'(size) - 1 - int'(c);
        return (v < 0) ? '0 : v[VALUE_W-1:0];
    endfunction

    function automatic void stage_event(input logic [CODE_W-1:0] code,
                                        input logic [VALUE_W-1:0] value);
        staged[staged_n].code  = code;
        staged[staged_n].value = value;
        staged[staged_n].last  = 1'b0;
        staged_n++;
    endfunction

    task automatic predict_touch_events(input logic k, input logic [7:0] xh, xl, yh, yl);
        logic [3:0]         id;
        logic [1:0]         touch_type;
        logic [VALUE_W-1:0] px;
        logic [VALUE_W-1:0] py;
        logic [VALUE_W-1:0] tmp;
        logic [SLOT_COUNT-1:0] released;
        t_touch_event       ev;
        staged_n = 0;
        if (k == KIND_POINT) begin
            id         = yh[7:4];
            touch_type = xh[7:6];
            px         = VALUE_W'({xh[3:0], xl});
            py         = VALUE_W'({yh[3:0], yl});
            if (int'(id) < SLOT_COUNT) begin
                seen_mask[id] = 1'b1;
                if (touch_type == TYPE_DOWN || touch_type == TYPE_CONTACT) begin
                    if (mirror_x) px = mirror_coord(screen_w, px[COORD_W-1:0]);
                    if (mirror_y) py = mirror_coord(screen_h, py[COORD_W-1:0]);
                    if (swap_xy) begin
                        tmp = px;
                        px  = py;
                        py  = tmp;
                    end
                    if (!slot_busy[id]) begin
                        slot_busy[id]  = 1'b1;
                        slot_track[id] = next_track;
                        next_track     = next_track + TRACKING_ID_BITS'(1);
                    end
                    stage_event(EVC_SLOT, VALUE_W'(id));
                    stage_event(EVC_TRACK, VALUE_W'(slot_track[id]));
                    stage_event(EVC_TOOL, '0);
                    stage_event(EVC_POS_X, px);
                    stage_event(EVC_POS_Y, py);
                    frame_active = 1'b1;
                end
            end
        end else begin
            // Slots known last frame but absent from this one are lifted.
            released = known_mask & ~seen_mask;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (released[i]) begin
                    slot_busy[i]  = 1'b0;
                    slot_track[i] = '0;
                    stage_event(EVC_SLOT, VALUE_W'(i));
                    stage_event(EVC_TRACK, '1);
                end
            end
            if (staged_n > 0 || frame_active) stage_event(EVC_SYNC, '0);
            known_mask   = seen_mask;
            seen_mask    = '0;
            frame_active = 1'b0;
        end
        for (int i = 0; i < staged_n; i++) begin
            ev      = staged[i];
            ev.last = (i == staged_n - 1);
            expected_events.push_back(ev);
        end
    endtask

    task automatic report_mismatch(input string what, input t_touch_event want,
                                   input t_touch_event got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t mst_event_checker: %s", $time, what);
            $display("    expected code %0d value %0d last %0d",
                     want.code, $signed(want.value), want.last);
            $display("    actual   code %0d value %0d last %0d",
                     got.code, $signed(got.value), got.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_touch_event got;
        t_touch_event want;
        if (!i_rst_n) begin
            expected_events.delete();
            mismatch_count = 0;
            screen_w       = WIDTH_RST;
            screen_h       = HEIGHT_RST;
            mirror_x       = 1'b1;
            mirror_y       = 1'b1;
            swap_xy        = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_busy[i]  = 1'b0;
                slot_track[i] = '0;
            end
            next_track   = '0;
            known_mask   = '0;
            seen_mask    = '0;
            frame_active = 1'b0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_SCREEN_WIDTH:  screen_w = i_pwdata[SIZE_W-1:0];
                    REG_SCREEN_HEIGHT: screen_h = i_pwdata[SIZE_W-1:0];
                    REG_FLIP_H:        mirror_x = i_pwdata[0];
                    REG_FLIP_V:        mirror_y = i_pwdata[0];
                    REG_SWAP_AXES:     swap_xy  = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.code  = i_event_code;
                got.value = i_event_value;
                got.last  = i_last_event;
                if (expected_events.size() == 0) begin
                    want = '0;
                    report_mismatch("event with nothing expected", want, got);
                end else begin
                    want = expected_events.pop_front();
                    if (want.code != got.code || want.value != got.value
                        || want.last != got.last)
                        report_mismatch("event mismatch", want, got);
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_touch_events(i_kind, i_x_high, i_x_low, i_y_high, i_y_low);
        end
        o_pending  <= expected_events.size();
        o_failures <= mismatch_count;
    end

endmodule

// ===== sim/multitouch_slot_tracker_unit_test.sv =====
// Testbench top for the multitouch slot tracker: drives touch records, end-of-frame
// marks and APB register writes, and gives the verdict from the checker's count.
// Depends on mst_pkg, multitouch_slot_tracker_unit and mst_event_checker.
module multitouch_slot_tracker_unit_test;
    import mst_pkg::*;

    localparam int SLOT_COUNT       = 10;
    localparam int TRACKING_ID_BITS = 16;
    // Lift-up touch types; the package only names the ones that make events.
    localparam logic [1:0] TYPE_LIFT     = 2'd1;
    localparam logic [1:0] TYPE_LIFT_ALT = 2'd3;
    // An end of frame without events still walks every slot.
    localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 8;

    logic                      i_clk;
    logic                      rst_n    = 1'b0;
    logic                      psel     = 1'b0;
    logic                      penable  = 1'b0;
    logic                      pwrite   = 1'b0;
    logic [ADDR_W-1:0]         paddr    = '0;
    logic [DATA_W-1:0]         pwdata   = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      kind     = KIND_POINT;
    logic [7:0]                x_high   = '0;
    logic [7:0]                x_low    = '0;
    logic [7:0]                y_high   = '0;
    logic [7:0]                y_low    = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [CODE_W-1:0]         event_code;
    logic signed [VALUE_W-1:0] event_value;
    logic                      last_event;

    int pending;
    int failures;
    int items_sent = 0;
    bit calm       = 1'b0;

    multitouch_slot_tracker_unit #(
        .SLOT_COUNT(SLOT_COUNT),
        .TRACKING_ID_BITS(TRACKING_ID_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_kind(kind),
        .i_x_high(x_high),
        .i_x_low(x_low),
        .i_y_high(y_high),
        .i_y_low(y_low),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_event_code(event_code),
        .o_event_value(event_value),
        .o_last_event(last_event)
    );

    mst_event_checker #(
        .SLOT_COUNT(SLOT_COUNT),
        .TRACKING_ID_BITS(TRACKING_ID_BITS)
    ) u_event_check (
        .i_clk(i_clk),
        .i_rst_n(rst_n),
        .i_psel(psel),
        .i_penable(penable),
        .i_pwrite(pwrite),
        .i_pready(pready),
        .i_paddr(paddr),
        .i_pwdata(pwdata),
        .i_in_valid(in_valid),
        .i_in_stall(in_stall),
        .i_kind(kind),
        .i_x_high(x_high),
        .i_x_low(x_low),
        .i_y_high(y_high),
        .i_y_low(y_low),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_event_code(event_code),
        .i_event_value(event_value),
        .i_last_event(last_event),
        .o_pending(pending),
        .o_failures(failures)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[multitouch_slot_tracker_unit] ERROR");
        $finish;
    end

    // Output side: raise stall at random before each transaction, and not at all while calm.
    initial begin
        int hold;
        do @(posedge i_clk); while (!rst_n);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    task automatic send_touch_item(input logic k, input logic [7:0] xh, xl, yh, yl);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        x_high   <= xh;
        x_low    <= xl;
        y_high   <= yh;
        y_low    <= yl;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_point(input logic [3:0] id, input logic [1:0] touch_type,
                              input logic [11:0] x, y);
        logic [1:0] spare;
        spare = 2'($urandom);
        send_touch_item(KIND_POINT, {touch_type, spare, x[11:8]}, x[7:0],
                        {id, y[11:8]}, y[7:0]);
    endtask

    task automatic send_end_of_frame();
        send_touch_item(KIND_FRAME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Let every expected event arrive, then give the block time to finish silent work.
    task automatic drain_events();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_screen(input logic [SIZE_W-1:0] w, h, input logic fh, fv, sw);
        write_reg(REG_SCREEN_WIDTH, DATA_W'(w));
        write_reg(REG_SCREEN_HEIGHT, DATA_W'(h));
        write_reg(REG_FLIP_H, DATA_W'(fh));
        write_reg(REG_FLIP_V, DATA_W'(fv));
        write_reg(REG_SWAP_AXES, DATA_W'(sw));
    endtask

    task automatic send_random_point(input int span);
        logic [3:0]  id;
        logic [1:0]  touch_type;
        logic [11:0] x;
        logic [11:0] y;
        int          pick;
        id   = ($urandom_range(0, 19) < 18) ? 4'($urandom_range(0, span))
                                            : 4'($urandom_range(SLOT_COUNT, 15));
        pick = $urandom_range(0, 9);
        if (pick < 7) touch_type = pick[0] ? TYPE_CONTACT : TYPE_DOWN;
        else          touch_type = pick[0] ? TYPE_LIFT : TYPE_LIFT_ALT;
        x = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(0, 1023));
        y = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(0, 1023));
        if ($urandom_range(0, 15) == 0) x = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        if ($urandom_range(0, 15) == 0) y = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        send_point(id, touch_type, x, y);
    endtask

    // A small id span keeps the same contacts alive over several frames.
    task automatic send_random_frame();
        int count;
        int span;
        calm  = ($urandom_range(0, 4) == 0);
        count = $urandom_range(0, SLOT_COUNT);
        span  = $urandom_range(0, SLOT_COUNT - 1);
        repeat (count) send_random_point(span);
        send_end_of_frame();
    endtask

    initial begin
        int half_mark;
        int phase_end;
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset configuration.
        send_end_of_frame();
        send_point(4'd0, TYPE_DOWN, 12'h000, 12'h000);
        send_point(4'd9, TYPE_CONTACT, 12'hFFF, 12'hFFF);
        send_point(4'd0, TYPE_CONTACT, 12'h321, 12'h123);
        send_point(4'd10, TYPE_DOWN, 12'h005, 12'h005);
        send_point(4'd15, TYPE_LIFT, 12'h0AA, 12'h055);
        send_point(4'd5, TYPE_LIFT, 12'h100, 12'h100);
        send_point(4'd3, TYPE_LIFT_ALT, 12'h200, 12'h080);
        send_end_of_frame();
        send_point(4'd3, TYPE_DOWN, 12'h31F, 12'h1DF);
        send_point(4'd9, TYPE_LIFT_ALT, 12'h010, 12'h020);
        send_end_of_frame();
        for (int i = 0; i < SLOT_COUNT; i++)
            send_point(4'(i), i[0] ? TYPE_CONTACT : TYPE_DOWN, 12'($urandom), 12'($urandom));
        send_end_of_frame();
        // Every slot was seen last frame and none this frame, so all are released.
        send_end_of_frame();

        for (int p = 0; p < 5; p++) begin
            drain_events();
            case (p)
                0: apply_screen(13'd4096, 13'd4096, 1'b0, 1'b0, 1'b1);
                1: apply_screen(13'd1, 13'd1, 1'b1, 1'b1, 1'b0);
                2: apply_screen(13'd0, 13'd8191, 1'b1, 1'b1, 1'b1);
                default: apply_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                                      1'($urandom), 1'($urandom), 1'($urandom));
            endcase
            half_mark = items_sent + 14;
            phase_end = items_sent + 28;
            while (items_sent < half_mark) send_random_frame();
            drain_events();
            while (items_sent < phase_end) send_random_frame();
        end

        drain_events();
        if (failures == 0)
            $display("[multitouch_slot_tracker_unit] OK");
        else
            $display("[multitouch_slot_tracker_unit] ERROR");
        $finish;
    end

endmodule
